>>> sv/rdoc_pkg.sv
// ----------------------------------------------------------------------------
// rdoc_pkg
// Shared widths and constants of the range digit occurrence counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdoc_pkg;

  localparam int VAL_W      = 30;
  localparam int OCC_W      = 34;
  localparam int DIG_W      = 4;
  localparam int NUM_DIGITS = 10;
  localparam int NUM_POS    = 10;
  localparam int BCD_W      = NUM_POS * DIG_W;
  localparam int POS_W      = 4;
  localparam int BCNT_W     = 5;

  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(NUM_DIGITS - 1);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(NUM_POS - 1);

endpackage

>>> sv/range_digit_occurrence_counter_unit.sv
// ----------------------------------------------------------------------------
// range_digit_occurrence_counter_unit
// Returns ten results, one per digit, for each accepted request.
// Takes one request at a time; the work is two bounds x ten positions x ten
// digits x two add or subtract steps on the single shared 34-bit accumulator
// adder, plus a 30-bit binary to decimal conversion per bound.
// Reset: asynchronous, idle and ready; no results pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_digit_occurrence_counter_unit import rdoc_pkg::*; #(
  parameter int MAX_DIGITS = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] first_value_i,
  input  logic [VAL_W-1:0] second_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DIG_W-1:0] digit_o,
  output logic [OCC_W-1:0] occurrences_o,
  output logic             last_o
);

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < k; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  localparam logic [63:0] LIM = pow10(MAX_DIGITS) - 64'd1;

  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ORDER = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_LN    = 4'd3;
  localparam logic [3:0] S_HP    = 4'd4;
  localparam logic [3:0] S_HM    = 4'd5;
  localparam logic [3:0] S_DIG   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]       state_q;
  logic             pass_q;
  logic             ph_q;
  logic [POS_W-1:0] pos_q;
  logic [DIG_W-1:0] dig_q;
  logic             start_q;

  logic [VAL_W-1:0] a_q, b_q, n_q, nb_q;
  logic [VAL_W-1:0] low_q, lownext_q, hp_q, hpm_q;
  logic [OCC_W-1:0] p_q;
  logic [OCC_W-1:0] pp_q;
  logic [OCC_W-1:0] acc_q [NUM_DIGITS];

  logic              cvt_done;
  logic [BCD_W-1:0]  bcd;
  logic [DIG_W-1:0]  cur;
  logic [VAL_W-1:0]  hi, lo;
  logic [OCC_W-1:0]  lowp1, base, extra, term, acc_d;
  logic              hp_nz;
  logic              in_acc, out_acc;
  logic [VAL_W+31:0] m_prod;

  rdoc_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .value_i (n_q),
    .done_o  (cvt_done),
    .bcd_o   (bcd)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign digit_o       = dig_q;
  assign occurrences_o = acc_q[dig_q];
  assign last_o        = (dig_q == LAST_DIGIT);

  assign cur   = bcd[pos_q*DIG_W +: DIG_W];
  assign hi    = (a_q < b_q) ? b_q : a_q;
  assign lo    = (a_q < b_q) ? a_q : b_q;
  assign hp_nz = (hp_q != '0);
  assign lowp1 = OCC_W'(low_q) + OCC_W'(1);

  assign m_prod = (VAL_W+32)'(n_q) * (VAL_W+32)'(RECIP10);

  always_comb begin
    if (dig_q == '0) begin
      base = hp_nz ? OCC_W'(hpm_q) : '0;
      if (!hp_nz) begin
        extra = '0;
      end else if (cur != '0) begin
        extra = p_q;
      end else begin
        extra = lowp1;
      end
    end else begin
      base = OCC_W'(hp_q);
      if (cur > dig_q) begin
        extra = p_q;
      end else if (cur == dig_q) begin
        extra = lowp1;
      end else begin
        extra = '0;
      end
    end
    term  = ph_q ? extra : base;
    acc_d = pass_q ? (acc_q[dig_q] - term) : (acc_q[dig_q] + term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
      ph_q    <= 1'b0;
      pos_q   <= '0;
      dig_q   <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_ORDER;
          end
        end
        S_ORDER: begin
          pass_q  <= 1'b0;
          start_q <= 1'b1;
          state_q <= S_CONV;
        end
        S_CONV: begin
          if (cvt_done) begin
            pos_q   <= '0;
            state_q <= S_LN;
          end
        end
        S_LN: begin
          state_q <= S_HP;
        end
        S_HP: begin
          state_q <= S_HM;
        end
        S_HM: begin
          dig_q   <= '0;
          ph_q    <= 1'b0;
          state_q <= S_DIG;
        end
        S_DIG: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (dig_q == LAST_DIGIT) begin
              state_q <= S_NEXT;
            end else begin
              dig_q <= dig_q + DIG_W'(1);
            end
          end
        end
        S_NEXT: begin
          if (pos_q == LAST_POS) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              start_q <= 1'b1;
              state_q <= S_CONV;
            end else begin
              dig_q   <= '0;
              state_q <= S_OUT;
            end
          end else begin
            pos_q   <= pos_q + POS_W'(1);
            state_q <= S_LN;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (dig_q == LAST_DIGIT) begin
              state_q <= S_IDLE;
            end else begin
              dig_q <= dig_q + DIG_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          a_q <= ({34'd0, first_value_i} > LIM) ? LIM[VAL_W-1:0] : first_value_i;
          b_q <= ({34'd0, second_value_i} > LIM) ? LIM[VAL_W-1:0] : second_value_i;
        end
      end
      S_ORDER: begin
        n_q  <= hi;
        nb_q <= (lo == '0) ? '0 : (lo - VAL_W'(1));
        for (int i = 0; i < NUM_DIGITS; i++) begin
          acc_q[i] <= '0;
        end
      end
      S_CONV: begin
        p_q   <= OCC_W'(1);
        pp_q  <= '0;
        low_q <= '0;
        hp_q  <= VAL_W'(m_prod >> RECIP10_SHIFT);
      end
      S_LN: begin
        lownext_q <= VAL_W'(OCC_W'(low_q) + OCC_W'(cur) * p_q);
      end
      S_HP: begin
        hp_q <= hp_q - VAL_W'(OCC_W'(cur) * pp_q);
      end
      S_HM: begin
        hpm_q <= hp_q - VAL_W'(p_q);
      end
      S_DIG: begin
        acc_q[dig_q] <= acc_d;
      end
      S_NEXT: begin
        low_q <= lownext_q;
        pp_q  <= p_q;
        p_q   <= (p_q << 3) + (p_q << 1);
        if (pos_q == LAST_POS && !pass_q) begin
          n_q <= nb_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/rdoc_bcd.sv
// ----------------------------------------------------------------------------
// rdoc_bcd
// Binary to decimal converter: shift-and-add-three, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdoc_bcd import rdoc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             done_o,
  output logic [BCD_W-1:0] bcd_o
);

  logic              busy_q;
  logic              done_q;
  logic [BCNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]  bin_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [BCD_W-1:0]  adj;

  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      if (bcd_q[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + BCNT_W'(1);
        if (cnt_q == BCNT_W'(VAL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[VAL_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
